>>> sv/mspfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the CRC-8 helper for the MSP v2 frame receiver.
// No dependencies; every module of the receiver imports this package.
package mspfr_pkg;

    // Header bytes and CRC-8 DVB-S2 constants.
    localparam logic [7:0] HDR_DOLLAR = 8'h24;
    localparam logic [7:0] HDR_X      = 8'h58;
    localparam logic [7:0] HDR_GT     = 8'h3E;
    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] CRC_TOP    = 8'h80;

    // Value of the store limit register after reset.
    localparam logic [15:0] STORE_LIMIT_RESET = 16'd32;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_WANT_X  = 4'd1,
        PH_WANT_GT = 4'd2,
        PH_FLAG    = 4'd3,
        PH_ID_LO   = 4'd4,
        PH_ID_HI   = 4'd5,
        PH_LEN_LO  = 4'd6,
        PH_LEN_HI  = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_CHECK   = 4'd9
    } t_phase;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_STORE = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    // One result word as it travels from the parser to the output stage.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] index;
        logic [7:0]  data;
        logic [15:0] id;
        logic [7:0]  flag;
        logic [15:0] length;
    } t_result;

    // CRC-8 DVB-S2 update over one byte, MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/mspfr_parser.sv
`timescale 1ns / 1ps
// Front end of the receiver: header hunt, field capture, running CRC and result classification.
// Depends on mspfr_pkg for the phase enum, result struct and CRC function.
module mspfr_parser import mspfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_store_limit,
    output logic        o_push,
    output t_result     o_result,
    output t_phase      o_phase
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_flag, n_flag;

    logic [7:0]  w_crc_next;
    logic [15:0] w_count_inc;
    logic [15:0] w_len_full;

    assign w_crc_next  = crc8_update(r_crc, i_byte);
    assign w_count_inc = r_count + 16'd1;
    assign w_len_full  = {i_byte, r_len[7:0]};
    assign o_phase     = r_phase;

    // Phase register and frame fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_crc   <= 8'h00;
            r_id    <= 16'h0000;
            r_len   <= 16'h0000;
            r_count <= 16'h0000;
            r_flag  <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    // Next phase, field updates and the result word for the accepted byte.
    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_id     = r_id;
        n_len    = r_len;
        n_count  = r_count;
        n_flag   = r_flag;
        o_push   = 1'b0;
        o_result = '{kind: KIND_STORE, index: 16'h0000, data: 8'h00,
                     id: r_id, flag: r_flag, length: r_len};
        if (i_take) begin
            unique case (r_phase)
                PH_WANT_X: begin
                    if (i_byte == HDR_X) begin
                        n_phase = PH_WANT_GT;
                    end else if (i_byte == HDR_DOLLAR) begin
                        n_phase = PH_WANT_X;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_WANT_GT: begin
                    if (i_byte == HDR_GT) begin
                        n_phase = PH_FLAG;
                    end else if (i_byte == HDR_DOLLAR) begin
                        n_phase = PH_WANT_X;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FLAG: begin
                    n_flag  = i_byte;
                    n_crc   = crc8_update(8'h00, i_byte);
                    n_phase = PH_ID_LO;
                end
                PH_ID_LO: begin
                    n_id    = {8'h00, i_byte};
                    n_crc   = w_crc_next;
                    n_phase = PH_ID_HI;
                end
                PH_ID_HI: begin
                    n_id    = {i_byte, r_id[7:0]};
                    n_crc   = w_crc_next;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_byte};
                    n_crc   = w_crc_next;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = w_len_full;
                    n_crc   = w_crc_next;
                    n_count = 16'h0000;
                    n_phase = (w_len_full == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc   = w_crc_next;
                    n_count = w_count_inc;
                    if (r_count < i_store_limit) begin
                        o_push         = 1'b1;
                        o_result.index = r_count;
                        o_result.data  = i_byte;
                    end
                    if (w_count_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_push        = 1'b1;
                    o_result.kind = (i_byte == r_crc) ? KIND_GOOD : KIND_BAD;
                    n_phase       = PH_HUNT;
                end
                default: begin
                    n_phase = (i_byte == HDR_DOLLAR) ? PH_WANT_X : PH_HUNT;
                end
            endcase
        end
    end

endmodule

>>> sv/mspfr_queue.sv
`timescale 1ns / 1ps
// Short result queue between the parser and the output stage.
// Depends on mspfr_pkg for the result struct.
module mspfr_queue import mspfr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_result                      i_wdata,
    input  logic                         i_pop,
    output t_result                      o_rdata,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_do_push, w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_count   = r_count;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd_ptr];

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/mspfr_out_stage.sv
`timescale 1ns / 1ps
// Back end of the receiver: registered output word with its valid/ready handshake.
// Depends on mspfr_pkg for the result struct.
module mspfr_out_stage import mspfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_avail,
    input  t_result i_word,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_word
);

    logic    r_valid;
    t_result r_word;

    // Load a new word whenever the register is empty or being drained.
    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_avail;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_word;
        end
    end

endmodule

>>> sv/msp_v2_frame_receiver.sv
`timescale 1ns / 1ps
// MSP v2 response frame receiver: takes one received serial byte per cycle, hunts for the
// '$' 'X' '>' header, captures flag, id and length, checks the CRC-8 DVB-S2 (0xD5) and emits
// one word per stored payload byte and one per frame end. A byte is taken every cycle while
// the result queue (QUEUE_DEPTH words) has room; the CRC is fully unrolled, so the only thing
// that slows input is a stalled output side filling the queue and output register. Results
// pass through the result queue and then the output register. The store limit register
// may be written at any cycle (o_cfg_ready is always high) but should change only when idle.
// Depends on mspfr_pkg, mspfr_parser, mspfr_queue and mspfr_out_stage.
module msp_v2_frame_receiver import mspfr_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received byte words.
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // Result words.
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_byte_index,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_message_id,
    output logic [7:0]  o_frame_flag,
    output logic [15:0] o_payload_length,
    // Store limit register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_store_limit
);

    logic [15:0] r_store_limit;
    logic        w_take;
    logic        w_push;
    t_result     w_push_word;
    t_phase      w_phase;
    t_result     w_q_word;
    logic        w_q_empty, w_q_full, w_pop;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] w_q_count;
    t_result     w_out_word;

    // Store limit register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_limit <= STORE_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_store_limit <= i_store_limit;
        end
    end

    // A byte is taken only when the queue can hold a possible result.
    assign o_rx_ready = !w_q_full;
    assign w_take     = i_rx_valid && o_rx_ready;

    mspfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_byte        (i_rx_byte),
        .i_store_limit (r_store_limit),
        .o_push        (w_push),
        .o_result      (w_push_word),
        .o_phase       (w_phase)
    );

    mspfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_word),
        .i_pop   (w_pop),
        .o_rdata (w_q_word),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_count (w_q_count)
    );

    mspfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!w_q_empty),
        .i_word  (w_q_word),
        .o_pop   (w_pop),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_word  (w_out_word)
    );

    // Unpack the output word onto the ports.
    assign o_result_kind    = w_out_word.kind;
    assign o_byte_index     = w_out_word.index;
    assign o_data_byte      = w_out_word.data;
    assign o_message_id     = w_out_word.id;
    assign o_frame_flag     = w_out_word.flag;
    assign o_payload_length = w_out_word.length;

    // Queue occupancy never goes past its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("result queue occupancy beyond depth");

    // A checksum byte always leaves a result waiting somewhere downstream.
    a_check_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_phase == PH_CHECK) |=> (o_res_valid || !w_q_empty))
        else $error("frame end produced no result");

    // Frame end words carry zero index and data.
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result_kind != KIND_STORE) |->
            (o_byte_index == 16'h0000 && o_data_byte == 8'h00))
        else $error("frame end word with payload fields set");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for msp_v2_frame_receiver: byte streams with MSP v2 frames and noise.
// Depends on mspfr_pkg and the receiver RTL; a built-in frame parser predicts every result word.
module tb_top import mspfr_pkg::*; ();

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic [1:0]  o_result_kind;
    logic [15:0] o_byte_index;
    logic [7:0]  o_data_byte;
    logic [15:0] o_message_id;
    logic [7:0]  o_frame_flag;
    logic [15:0] o_payload_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_store_limit = 16'h0000;

    // Percent of cycles in which each side holds off.
    int rx_idle_pct;
    int res_idle_pct;
    int rx_count;

    // Frame parser that mirrors the receiver and queues the result words it should emit.
    class msp_frame_checker;
        t_phase      hunt_state;
        logic [7:0]  crc_acc;
        logic [15:0] cur_id;
        logic [15:0] cur_len;
        logic [15:0] pay_idx;
        logic [7:0]  cur_flag;
        logic [15:0] limit;
        t_result     expected_words[$];
        int          fails;

        function new();
            hunt_state = PH_HUNT;
            crc_acc = 8'h00;
            cur_id = 16'h0000;
            cur_len = 16'h0000;
            pay_idx = 16'h0000;
            cur_flag = 8'h00;
            limit = STORE_LIMIT_RESET;
            fails = 0;
        endfunction

        // CRC-8 DVB-S2, one input bit at a time, MSB first.
        static function logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] din);
            logic [7:0] r;
            r = acc;
            for (int i = 7; i >= 0; i--) begin
                if (r[7] ^ din[i]) begin
                    r = {r[6:0], 1'b0} ^ CRC_POLY;
                end else begin
                    r = {r[6:0], 1'b0};
                end
            end
            return r;
        endfunction

        function void push_word(input t_kind k, input logic [15:0] idx, input logic [7:0] d);
            t_result w;
            w.kind = k;
            w.index = idx;
            w.data = d;
            w.id = cur_id;
            w.flag = cur_flag;
            w.length = cur_len;
            expected_words.push_back(w);
        endfunction

        // Advance the parser by one accepted byte.
        function void take_rx_byte(input logic [7:0] rb);
            case (hunt_state)
                PH_WANT_X: begin
                    if (rb == HDR_X) hunt_state = PH_WANT_GT;
                    else if (rb == HDR_DOLLAR) hunt_state = PH_WANT_X;
                    else hunt_state = PH_HUNT;
                end
                PH_WANT_GT: begin
                    if (rb == HDR_GT) hunt_state = PH_FLAG;
                    else if (rb == HDR_DOLLAR) hunt_state = PH_WANT_X;
                    else hunt_state = PH_HUNT;
                end
                PH_FLAG: begin
                    cur_flag = rb;
                    crc_acc = crc_step(8'h00, rb);
                    hunt_state = PH_ID_LO;
                end
                PH_ID_LO: begin
                    cur_id = {8'h00, rb};
                    crc_acc = crc_step(crc_acc, rb);
                    hunt_state = PH_ID_HI;
                end
                PH_ID_HI: begin
                    cur_id[15:8] = rb;
                    crc_acc = crc_step(crc_acc, rb);
                    hunt_state = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    cur_len = {8'h00, rb};
                    crc_acc = crc_step(crc_acc, rb);
                    hunt_state = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    cur_len[15:8] = rb;
                    crc_acc = crc_step(crc_acc, rb);
                    pay_idx = 16'h0000;
                    hunt_state = (cur_len == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    crc_acc = crc_step(crc_acc, rb);
                    if (pay_idx < limit) push_word(KIND_STORE, pay_idx, rb);
                    pay_idx = pay_idx + 16'd1;
                    if (pay_idx >= cur_len) hunt_state = PH_CHECK;
                end
                PH_CHECK: begin
                    push_word((rb == crc_acc) ? KIND_GOOD : KIND_BAD, 16'h0000, 8'h00);
                    hunt_state = PH_HUNT;
                end
                default: begin
                    hunt_state = (rb == HDR_DOLLAR) ? PH_WANT_X : PH_HUNT;
                end
            endcase
        endfunction

        // Compare one accepted result word with the oldest expected one.
        function void check_word(input t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display({"unexpected result word: kind %0d index %0d data %02h",
                              " id %04h flag %02h length %0d"},
                             got.kind, got.index, got.data, got.id, got.flag, got.length);
            end else begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind || got.index !== want.index ||
                    got.data !== want.data || got.id !== want.id ||
                    got.flag !== want.flag || got.length !== want.length) begin
                    fails++;
                    if (fails <= 10) begin
                        $display({"result mismatch: expected kind %0d index %0d data %02h",
                                  " id %04h flag %02h length %0d"},
                                 want.kind, want.index, want.data, want.id, want.flag,
                                 want.length);
                        $display({"                 got      kind %0d index %0d data %02h",
                                  " id %04h flag %02h length %0d"},
                                 got.kind, got.index, got.data, got.id, got.flag,
                                 got.length);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    msp_frame_checker sb;

    msp_v2_frame_receiver uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_result_kind    (o_result_kind),
        .o_byte_index     (o_byte_index),
        .o_data_byte      (o_data_byte),
        .o_message_id     (o_message_id),
        .o_frame_flag     (o_frame_flag),
        .o_payload_length (o_payload_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_store_limit    (i_store_limit)
    );

    // Free-running 2 ns clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result side: check every accepted word, then pick the next ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            sb.check_word(t_result'({o_result_kind, o_byte_index, o_data_byte,
                                     o_message_id, o_frame_flag, o_payload_length}));
        i_res_ready <= ($urandom_range(0, 99) >= res_idle_pct);
    end

    // Hang detector: any handshake restarts the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offer one byte word, with an optional random gap first, and wait until it is taken.
    task automatic send_rx(input logic [7:0] rb);
        if ($urandom_range(0, 99) < rx_idle_pct) begin
            i_rx_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < rx_idle_pct);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= rb;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.take_rx_byte(rb);
        rx_count++;
    endtask

    task automatic send_field(input logic [7:0] v, inout logic [7:0] crc);
        crc = msp_frame_checker::crc_step(crc, v);
        send_rx(v);
    endtask

    // Whole frame with random payload; spoil flips one checksum bit.
    task automatic send_frame(input logic [7:0] fl, input logic [15:0] id,
                              input logic [15:0] len, input bit spoil);
        logic [7:0] crc;
        int i;
        crc = 8'h00;
        send_rx(HDR_DOLLAR);
        send_rx(HDR_X);
        send_rx(HDR_GT);
        send_field(fl, crc);
        send_field(id[7:0], crc);
        send_field(id[15:8], crc);
        send_field(len[7:0], crc);
        send_field(len[15:8], crc);
        for (i = 0; i < len; i++) send_field(8'($urandom_range(0, 255)), crc);
        if (spoil) crc = crc ^ (8'h01 << $urandom_range(0, 7));
        send_rx(crc);
    endtask

    // Mostly well-formed frames, some broken headers and stray bytes.
    task automatic run_mixed(input int n);
        int start;
        int pick;
        int lsel;
        logic [15:0] len;
        start = rx_count;
        while (rx_count - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                lsel = $urandom_range(0, 99);
                if (lsel < 70) len = 16'($urandom_range(0, 8));
                else if (lsel < 95) len = 16'($urandom_range(9, 40));
                else len = 16'($urandom_range(41, 200));
                send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), len,
                           $urandom_range(0, 99) < 15);
            end else if (pick < 85) begin
                send_rx(HDR_DOLLAR);
                if ($urandom_range(0, 1) == 1) send_rx(HDR_X);
                send_rx(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_rx(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Let every expected word arrive, then allow for the output pipeline.
    task automatic drain();
        i_rx_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_store_limit(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_store_limit <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.limit = v;
    endtask

    // Main sequence.
    initial begin
        sb = new();
        rx_count = 0;
        rx_idle_pct = 11;
        res_idle_pct = 52;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stray bytes, a repeated dollar before the header, an empty payload
        // with all-ones fields, a header broken by a new dollar, and a bad checksum.
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(HDR_DOLLAR);
        send_frame(8'hFF, 16'hFFFF, 16'd0, 1'b0);
        send_rx(HDR_DOLLAR);
        send_rx(HDR_X);
        send_frame(8'h00, 16'h0000, 16'd1, 1'b1);
        drain();

        // Nothing stored, frames still checked.
        set_store_limit(16'd0);
        run_mixed(200);
        drain();

        rx_idle_pct = 52;
        res_idle_pct = 11;
        set_store_limit(16'd3);
        run_mixed(200);
        drain();

        set_store_limit(16'hFFFF);
        run_mixed(200);
        drain();

        rx_idle_pct = 0;
        res_idle_pct = 0;
        set_store_limit(16'($urandom_range(1, 40)));
        run_mixed(200);
        drain();

        // One long frame, every payload byte stored.
        set_store_limit(16'hFFFF);
        send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 16'd100, 1'b0);
        drain();

        if (sb.fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> msp_v2_frame_receiver.f
sv/mspfr_pkg.sv
sv/mspfr_parser.sv
sv/mspfr_queue.sv
sv/mspfr_out_stage.sv
sv/msp_v2_frame_receiver.sv
tb/tb_top.sv
